FILE: hdl/dcgh_pkg.sv
// shared constants, register codes and result formatting for the distance gradient/hessian core
`timescale 1ns / 1ps
package dcgh_pkg;

   // quotient bits produced by the divider chains (magnitude below 2^31)
   localparam int QUOT_BITS = 31;
   // width of every result field
   localparam int OUT_W     = 32;
   // fraction bits of the gradient
   localparam int GRAD_FRAC = 30;
   // number of result fields in rsp_tdata
   localparam int NUM_RES   = 9;
   // csr index width
   localparam int CSR_IDX_W = 3;

   // operand pairs of the off-diagonal entries: xy, xz, yz
   localparam int PAIR_A [3] = '{0, 0, 1};
   localparam int PAIR_B [3] = '{1, 2, 2};

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_REF_FIRST_X  = 3'd0,
      CSR_REF_FIRST_Y  = 3'd1,
      CSR_REF_FIRST_Z  = 3'd2,
      CSR_REF_SECOND_X = 3'd3,
      CSR_REF_SECOND_Y = 3'd4,
      CSR_REF_SECOND_Z = 3'd5,
      CSR_NEGATE       = 3'd6
   } csr_index_type;

   // magnitude and sign to two's complement, clamped at the 32-bit limits
   function automatic logic [OUT_W-1:0] emit_q(input logic [QUOT_BITS-1:0] mag,
                                               input logic sat, input logic neg);
      logic [OUT_W-1:0] ext;
      logic [OUT_W-1:0] res;
      ext = {1'b0, mag};
      if (sat) begin
         res = neg ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
      end else begin
         res = neg ? (~ext + OUT_W'(1)) : ext;
      end
      return res;
   endfunction

endpackage

FILE: hdl/dcgh_sqrt_cell.sv
// one stage of the floor square root chain: two radicand bits, one root bit
`timescale 1ns / 1ps
module dcgh_sqrt_cell #(
   parameter int MAG_W  = 34,
   parameter int SIDE_W = 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 adv,
   input  logic                 in_valid,
   input  logic [2*MAG_W-1:0]   in_rad,
   input  logic [MAG_W:0]       in_rem,
   input  logic [MAG_W-1:0]     in_root,
   input  logic [SIDE_W-1:0]    in_side,
   output logic                 out_valid,
   output logic [2*MAG_W-1:0]   out_rad,
   output logic [MAG_W:0]       out_rem,
   output logic [MAG_W-1:0]     out_root,
   output logic [SIDE_W-1:0]    out_side
);

   logic [MAG_W+2:0] cur_w;
   logic [MAG_W+2:0] trial_w;
   logic [MAG_W+2:0] diff_w;
   logic             fits_w;

   logic               valid_ff;
   logic [2*MAG_W-1:0] rad_ff,  rad_in;
   logic [MAG_W:0]     rem_ff,  rem_in;
   logic [MAG_W-1:0]   root_ff, root_in;
   logic [SIDE_W-1:0]  side_ff;

   // trial subtract of (4*root + 1) from the shifted remainder
   always_comb begin
      cur_w   = {in_rem, in_rad[2*MAG_W-1 -: 2]};
      trial_w = {1'b0, in_root, 2'b01};
      diff_w  = cur_w - trial_w;
      fits_w  = (cur_w >= trial_w);
      rem_in  = fits_w ? diff_w[MAG_W:0] : cur_w[MAG_W:0];
      root_in = {in_root[MAG_W-2:0], fits_w};
      rad_in  = {in_rad[2*MAG_W-3:0], 2'b00};
   end

   // stage register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rad_ff  <= rad_in;
         rem_ff  <= rem_in;
         root_ff <= root_in;
         side_ff <= in_side;
      end
   end

   assign out_valid = valid_ff;
   assign out_rad   = rad_ff;
   assign out_rem   = rem_ff;
   assign out_root  = root_ff;
   assign out_side  = side_ff;

endmodule

FILE: hdl/dcgh_div_cell.sv
// one stage of a restoring divider chain: one quotient bit for each lane
`timescale 1ns / 1ps
module dcgh_div_cell #(
   parameter int LANES  = 3,
   parameter int DEN_W  = 34,
   parameter int SIDE_W = 1
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        adv,
   input  logic                                        in_valid,
   input  logic [DEN_W-1:0]                            in_den,
   input  logic [LANES-1:0][DEN_W-1:0]                 in_rem,
   input  logic [LANES-1:0][dcgh_pkg::QUOT_BITS-1:0]   in_rq,
   input  logic [SIDE_W-1:0]                           in_side,
   output logic                                        out_valid,
   output logic [DEN_W-1:0]                            out_den,
   output logic [LANES-1:0][DEN_W-1:0]                 out_rem,
   output logic [LANES-1:0][dcgh_pkg::QUOT_BITS-1:0]   out_rq,
   output logic [SIDE_W-1:0]                           out_side
);
   import dcgh_pkg::*;

   logic [LANES-1:0][DEN_W:0]     cur_w;
   logic [LANES-1:0][DEN_W:0]     diff_w;
   logic [LANES-1:0]              fits_w;
   logic [LANES-1:0][DEN_W-1:0]   rem_in;
   logic [LANES-1:0][QUOT_BITS-1:0] rq_in;

   logic                            valid_ff;
   logic [DEN_W-1:0]                den_ff;
   logic [LANES-1:0][DEN_W-1:0]     rem_ff;
   logic [LANES-1:0][QUOT_BITS-1:0] rq_ff;
   logic [SIDE_W-1:0]               side_ff;

   // next numerator bit enters the remainder, quotient bit enters at the bottom
   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         cur_w[l]  = {in_rem[l], in_rq[l][QUOT_BITS-1]};
         diff_w[l] = cur_w[l] - {1'b0, in_den};
         fits_w[l] = (cur_w[l] >= {1'b0, in_den});
         rem_in[l] = fits_w[l] ? diff_w[l][DEN_W-1:0] : cur_w[l][DEN_W-1:0];
         rq_in[l]  = {in_rq[l][QUOT_BITS-2:0], fits_w[l]};
      end
   end

   // stage register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         den_ff  <= in_den;
         rem_ff  <= rem_in;
         rq_ff   <= rq_in;
         side_ff <= in_side;
      end
   end

   assign out_valid = valid_ff;
   assign out_den   = den_ff;
   assign out_rem   = rem_ff;
   assign out_rq    = rq_ff;
   assign out_side  = side_ff;

endmodule

FILE: hdl/distance_constraint_gradient_hessian_core.sv
// top level: distance constraint gradient and hessian between two points
`timescale 1ns / 1ps
// Usage
// - req channel: one item holds six displacements (first x,y,z then second
//   x,y,z), each COORD_WIDTH bits signed with FRAC_BITS fraction bits.
// - rsp channel: one item per request with the three gradient entries (Q2.30)
//   and the six distinct hessian entries (saturated); tuser flags coinciding
//   points, in which case all data is zero.
// - csr port: write-only, index 0..5 reference positions, 6 the sign flip;
//   write only while no item is in flight.
// An item runs to rsp_tvalid through COORD_WIDTH + 40 register stages, the
// first loaded at the accepting edge: three front stages, one square root
// cell per root bit (COORD_WIDTH + 2), three stages for the length cube, one
// divider cell per quotient bit (31) and the output register.
// Throughput is one item per cycle while no result is stalled at the output.
// When the receiver stalls with a result waiting, the whole chain holds and
// req_tready drops; it rises again in the cycle the result is taken.
// Reset clears all valid bits and the configuration registers.
module distance_constraint_gradient_hessian_core #(
   parameter int COORD_WIDTH = 32,
   parameter int FRAC_BITS   = 16
) (
   input  logic                                            clock,
   input  logic                                            reset,
   // disp_first_x, disp_first_y, disp_first_z, disp_second_x, y, z
   input  logic                                            req_tvalid,
   output logic                                            req_tready,
   input  logic [((6*COORD_WIDTH+7)/8)*8-1:0]               req_tdata,
   // grad_x, grad_y, grad_z, hess_xx, hess_yy, hess_zz, hess_xy, hess_xz, hess_yz
   output logic                                            rsp_tvalid,
   input  logic                                            rsp_tready,
   output logic [dcgh_pkg::NUM_RES*dcgh_pkg::OUT_W-1:0]    rsp_tdata,
   // degenerate
   output logic                                            rsp_tuser,
   input  logic                                            csr_we,
   input  logic [dcgh_pkg::CSR_IDX_W-1:0]                  csr_index,
   input  logic [COORD_WIDTH-1:0]                          csr_wdata
);
   import dcgh_pkg::*;

   localparam int CW      = COORD_WIDTH;
   localparam int MW      = CW + 2;
   localparam int SQ_W    = 2 * MW;
   localparam int L3_W    = 3 * MW;
   localparam int GN_W    = MW + GRAD_FRAC;
   localparam int HN_W    = SQ_W + 2 * FRAC_BITS;
   localparam int SIDE_W  = 6 * SQ_W + 3 * MW + 3;
   localparam int GSIDE_W = 6;
   localparam int HSIDE_W = 6;

   // configuration registers
   logic [5:0][CW-1:0] ref_ff;
   logic               negate_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_ff    <= '0;
         negate_ff <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_REF_FIRST_X:  ref_ff[0] <= csr_wdata;
            CSR_REF_FIRST_Y:  ref_ff[1] <= csr_wdata;
            CSR_REF_FIRST_Z:  ref_ff[2] <= csr_wdata;
            CSR_REF_SECOND_X: ref_ff[3] <= csr_wdata;
            CSR_REF_SECOND_Y: ref_ff[4] <= csr_wdata;
            CSR_REF_SECOND_Z: ref_ff[5] <= csr_wdata;
            CSR_NEGATE:       negate_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // whole chain moves unless a finished result is stuck at the output
   logic adv;
   logic rsp_valid_ff;

   assign adv        = !rsp_valid_ff || rsp_tready;
   assign req_tready = adv;

   // stage 1: positions, separation, sign and magnitude
   logic [2:0][CW:0]   pf_w, ps_w;
   logic [2:0][MW-1:0] d_w, mag1_in;
   logic [2:0]         neg1_in;
   logic               v1_ff;
   logic [2:0][MW-1:0] mag1_ff;
   logic [2:0]         neg1_ff;

   for (genvar i = 0; i < 3; i++) begin : g_sep
      assign pf_w[i] = {ref_ff[i][CW-1], ref_ff[i]}
                     + {req_tdata[i*CW+CW-1], req_tdata[i*CW +: CW]};
      assign ps_w[i] = {ref_ff[i+3][CW-1], ref_ff[i+3]}
                     + {req_tdata[(i+3)*CW+CW-1], req_tdata[(i+3)*CW +: CW]};
      assign d_w[i]     = {pf_w[i][CW], pf_w[i]} - {ps_w[i][CW], ps_w[i]};
      assign neg1_in[i] = d_w[i][MW-1];
      assign mag1_in[i] = neg1_in[i] ? (~d_w[i] + MW'(1)) : d_w[i];
   end

   // stage 2: squares and cross products
   logic [2:0][SQ_W-1:0] sq2_in, pr2_in;
   logic                 v2_ff;
   logic [2:0][SQ_W-1:0] sq2_ff, pr2_ff;
   logic [2:0][MW-1:0]   mag2_ff;
   logic [2:0]           neg2_ff;

   for (genvar i = 0; i < 3; i++) begin : g_mul
      assign sq2_in[i] = SQ_W'(mag1_ff[i]) * SQ_W'(mag1_ff[i]);
      assign pr2_in[i] = SQ_W'(mag1_ff[PAIR_A[i]]) * SQ_W'(mag1_ff[PAIR_B[i]]);
   end

   // stage 3: squared length and hessian numerators
   logic [SQ_W-1:0]      l2_in;
   logic [5:0][SQ_W-1:0] hnum3_in;
   logic                 v3_ff;
   logic [SQ_W-1:0]      l2_3_ff;
   logic [5:0][SQ_W-1:0] hnum3_ff;
   logic [2:0][MW-1:0]   mag3_ff;
   logic [2:0]           neg3_ff;

   assign l2_in = sq2_ff[0] + sq2_ff[1] + sq2_ff[2];
   for (genvar i = 0; i < 3; i++) begin : g_num
      assign hnum3_in[i]     = l2_in - sq2_ff[i];
      assign hnum3_in[i + 3] = pr2_ff[i];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= req_tvalid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         mag1_ff  <= mag1_in;
         neg1_ff  <= neg1_in;
         sq2_ff   <= sq2_in;
         pr2_ff   <= pr2_in;
         mag2_ff  <= mag1_ff;
         neg2_ff  <= neg1_ff;
         l2_3_ff  <= l2_in;
         hnum3_ff <= hnum3_in;
         mag3_ff  <= mag2_ff;
         neg3_ff  <= neg2_ff;
      end
   end

   // square root chain, one cell per root bit
   logic              sq_v    [0:MW];
   logic [SQ_W-1:0]   sq_rad  [0:MW];
   logic [MW:0]       sq_rem  [0:MW];
   logic [MW-1:0]     sq_root [0:MW];
   logic [SIDE_W-1:0] sq_side [0:MW];

   assign sq_v[0]    = v3_ff;
   assign sq_rad[0]  = l2_3_ff;
   assign sq_rem[0]  = '0;
   assign sq_root[0] = '0;
   assign sq_side[0] = {hnum3_ff, mag3_ff, neg3_ff};

   for (genvar g = 0; g < MW; g++) begin : g_sqrt
      dcgh_sqrt_cell #(
         .MAG_W  (MW),
         .SIDE_W (SIDE_W)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .adv       (adv),
         .in_valid  (sq_v[g]),
         .in_rad    (sq_rad[g]),
         .in_rem    (sq_rem[g]),
         .in_root   (sq_root[g]),
         .in_side   (sq_side[g]),
         .out_valid (sq_v[g+1]),
         .out_rad   (sq_rad[g+1]),
         .out_rem   (sq_rem[g+1]),
         .out_root  (sq_root[g+1]),
         .out_side  (sq_side[g+1])
      );
   end

   // stages 4 to 6: length cubed, upper and lower halves multiplied apart
   logic              v4_ff, v5_ff, v6_ff;
   logic [MW-1:0]     len4_ff, len5_ff, len6_ff;
   logic [SQ_W-1:0]   lsq4_ff, plo5_ff, phi5_ff;
   logic [L3_W-1:0]   len3_6_ff;
   logic [SIDE_W-1:0] side4_ff, side5_ff, side6_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else if (adv) begin
         v4_ff <= sq_v[MW];
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         len4_ff   <= sq_root[MW];
         lsq4_ff   <= SQ_W'(sq_root[MW]) * SQ_W'(sq_root[MW]);
         side4_ff  <= sq_side[MW];
         len5_ff   <= len4_ff;
         plo5_ff   <= SQ_W'(lsq4_ff[MW-1:0]) * SQ_W'(len4_ff);
         phi5_ff   <= SQ_W'(lsq4_ff[SQ_W-1:MW]) * SQ_W'(len4_ff);
         side5_ff  <= side4_ff;
         len6_ff   <= len5_ff;
         len3_6_ff <= L3_W'(plo5_ff) + {phi5_ff, {MW{1'b0}}};
         side6_ff  <= side5_ff;
      end
   end

   // divider set-up: saturation test and starting remainder per lane
   logic [5:0][SQ_W-1:0]        hnum6_w;
   logic [2:0][MW-1:0]          mag6_w;
   logic [2:0]                  neg6_w;
   logic [2:0][GN_W-1:0]        gnum_w;
   logic [2:0][MW-1:0]          ghi_w;
   logic [2:0]                  gsat_w;
   logic [2:0][MW-1:0]          grem0_w;
   logic [2:0][QUOT_BITS-1:0]   grq0_w;
   logic [5:0][HN_W-1:0]        hnumq_w;
   logic [5:0][L3_W-1:0]        hhi_w;
   logic [5:0]                  hsat_w;
   logic [5:0][L3_W-1:0]        hrem0_w;
   logic [5:0][QUOT_BITS-1:0]   hrq0_w;

   assign {hnum6_w, mag6_w, neg6_w} = side6_ff;

   for (genvar i = 0; i < 3; i++) begin : g_ghead
      assign gnum_w[i]  = {mag6_w[i], {GRAD_FRAC{1'b0}}};
      assign ghi_w[i]   = MW'(gnum_w[i][GN_W-1:QUOT_BITS]);
      assign gsat_w[i]  = (ghi_w[i] >= len6_ff);
      assign grem0_w[i] = gsat_w[i] ? '0 : ghi_w[i];
      assign grq0_w[i]  = gnum_w[i][QUOT_BITS-1:0];
   end

   for (genvar j = 0; j < 6; j++) begin : g_hhead
      assign hnumq_w[j] = {hnum6_w[j], {(2*FRAC_BITS){1'b0}}};
      assign hhi_w[j]   = L3_W'(hnumq_w[j][HN_W-1:QUOT_BITS]);
      assign hsat_w[j]  = (hhi_w[j] >= len3_6_ff);
      assign hrem0_w[j] = hsat_w[j] ? '0 : hhi_w[j];
      assign hrq0_w[j]  = hnumq_w[j][QUOT_BITS-1:0];
   end

   // gradient divider chain over the length
   logic                          gv    [0:QUOT_BITS];
   logic [MW-1:0]                 gden  [0:QUOT_BITS];
   logic [2:0][MW-1:0]            grem  [0:QUOT_BITS];
   logic [2:0][QUOT_BITS-1:0]     grq   [0:QUOT_BITS];
   logic [GSIDE_W-1:0]            gside [0:QUOT_BITS];

   assign gv[0]    = v6_ff;
   assign gden[0]  = len6_ff;
   assign grem[0]  = grem0_w;
   assign grq[0]   = grq0_w;
   assign gside[0] = {gsat_w, neg6_w};

   // hessian divider chain over the length cubed
   logic                          hv    [0:QUOT_BITS];
   logic [L3_W-1:0]               hden  [0:QUOT_BITS];
   logic [5:0][L3_W-1:0]          hrem  [0:QUOT_BITS];
   logic [5:0][QUOT_BITS-1:0]     hrq   [0:QUOT_BITS];
   logic [HSIDE_W-1:0]            hside [0:QUOT_BITS];

   assign hv[0]    = v6_ff;
   assign hden[0]  = len3_6_ff;
   assign hrem[0]  = hrem0_w;
   assign hrq[0]   = hrq0_w;
   assign hside[0] = hsat_w;

   for (genvar g = 0; g < QUOT_BITS; g++) begin : g_div
      dcgh_div_cell #(
         .LANES  (3),
         .DEN_W  (MW),
         .SIDE_W (GSIDE_W)
      ) u_grad (
         .clock     (clock),
         .reset     (reset),
         .adv       (adv),
         .in_valid  (gv[g]),
         .in_den    (gden[g]),
         .in_rem    (grem[g]),
         .in_rq     (grq[g]),
         .in_side   (gside[g]),
         .out_valid (gv[g+1]),
         .out_den   (gden[g+1]),
         .out_rem   (grem[g+1]),
         .out_rq    (grq[g+1]),
         .out_side  (gside[g+1])
      );

      dcgh_div_cell #(
         .LANES  (6),
         .DEN_W  (L3_W),
         .SIDE_W (HSIDE_W)
      ) u_hess (
         .clock     (clock),
         .reset     (reset),
         .adv       (adv),
         .in_valid  (hv[g]),
         .in_den    (hden[g]),
         .in_rem    (hrem[g]),
         .in_rq     (hrq[g]),
         .in_side   (hside[g]),
         .out_valid (hv[g+1]),
         .out_den   (hden[g+1]),
         .out_rem   (hrem[g+1]),
         .out_rq    (hrq[g+1]),
         .out_side  (hside[g+1])
      );
   end

   // result formatting: signs, saturation, coinciding points
   logic [2:0]                 gsat_e, gneg_e;
   logic [5:0]                 hsat_e;
   logic                       degen_in;
   logic [NUM_RES-1:0][OUT_W-1:0] res_in;
   logic [NUM_RES-1:0][OUT_W-1:0] res_ff;
   logic                       degen_ff;

   assign {gsat_e, gneg_e} = gside[QUOT_BITS];
   assign hsat_e           = hside[QUOT_BITS];
   assign degen_in         = (gden[QUOT_BITS] == '0);

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         res_in[i]     = emit_q(grq[QUOT_BITS][i], gsat_e[i], gneg_e[i] ^ negate_ff);
         res_in[i + 3] = emit_q(hrq[QUOT_BITS][i], hsat_e[i], negate_ff);
         res_in[i + 6] = emit_q(hrq[QUOT_BITS][i + 3], hsat_e[i + 3],
                                (gneg_e[PAIR_A[i]] == gneg_e[PAIR_B[i]]) ^ negate_ff);
      end
      if (degen_in) begin
         res_in = '0;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= gv[QUOT_BITS] && hv[QUOT_BITS];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         res_ff   <= res_in;
         degen_ff <= degen_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = res_ff;
   assign rsp_tuser  = degen_ff;

endmodule

FILE: hdl/dcgh_checker.sv
// port-level checks for the distance gradient/hessian core, bound to the top level
`timescale 1ns / 1ps
module dcgh_checker (
   input logic                                         clock,
   input logic                                         reset,
   input logic                                         req_tready,
   input logic                                         rsp_tvalid,
   input logic                                         rsp_tready,
   input logic [dcgh_pkg::NUM_RES*dcgh_pkg::OUT_W-1:0] rsp_tdata,
   input logic                                         rsp_tuser
);
   import dcgh_pkg::*;

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   // coinciding points give all-zero data
   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == '0)
      else $error("degenerate item with nonzero data");

   // nothing comes out right after reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // input side is open whenever no result waits
   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with empty output");

   // gradient entries stay within one in Q2.30
   a_grad_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |->
         ($signed(rsp_tdata[31:0])  <= 32'sd1073741824) &&
         ($signed(rsp_tdata[31:0])  >= -32'sd1073741824) &&
         ($signed(rsp_tdata[63:32]) <= 32'sd1073741824) &&
         ($signed(rsp_tdata[63:32]) >= -32'sd1073741824) &&
         ($signed(rsp_tdata[95:64]) <= 32'sd1073741824) &&
         ($signed(rsp_tdata[95:64]) >= -32'sd1073741824))
      else $error("gradient out of range");

endmodule

bind distance_constraint_gradient_hessian_core dcgh_checker u_dcgh_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
